// ----- design/bole_pkg.sv -----
// ----------------------------------------------------------------------------
// bole_pkg
// Shared widths, action and status codes, and controller/datapath interface
// types for the bounded ordered list engine.
// ----------------------------------------------------------------------------
package bole_pkg;

  localparam int unsigned ACT_W     = 3;
  localparam int unsigned VAL_W     = 32;
  localparam int unsigned POS_W     = 5;
  localparam int unsigned STAT_W    = 2;
  localparam int unsigned FND_W     = 4;
  localparam int unsigned CNT_OUT_W = 5;
  localparam int unsigned LIM_W     = 5;

  localparam int unsigned DEF_CAPACITY = 16;
  localparam logic [LIM_W-1:0] LIM_RESET = 5'd16;

  // actions
  localparam logic [ACT_W-1:0] ACT_INS_FRONT = 3'd0;
  localparam logic [ACT_W-1:0] ACT_INS_BACK  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_INS_AT    = 3'd2;
  localparam logic [ACT_W-1:0] ACT_REM_FRONT = 3'd3;
  localparam logic [ACT_W-1:0] ACT_REM_BACK  = 3'd4;
  localparam logic [ACT_W-1:0] ACT_REM_AT    = 3'd5;
  localparam logic [ACT_W-1:0] ACT_SEARCH    = 3'd6;

  // result status
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd3;

  // entry RAM read address source
  typedef enum logic [1:0] {
    RD_AT,
    RD_IDX,
    RD_PREV,
    RD_NEXT
  } rd_sel_e;

  typedef struct packed {
    logic              load_in;
    logic              idx_cnt;
    logic              idx_at;
    logic              idx_zero;
    logic              idx_inc;
    logic              idx_dec;
    logic              rd_en;
    rd_sel_e           rd_sel;
    logic              wr_en;
    logic              wr_from_ram;
    logic              cnt_inc;
    logic              cnt_dec;
    logic              take;
    logic              found;
    logic              status_load;
    logic [STAT_W-1:0] status_code;
    logic              out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [ACT_W-1:0] act;
    logic             full;
    logic             empty;
    logic             rem_bad;
    logic             at_idx;
    logic             last;
    logic             match;
  } dp_stat_t;

endpackage

// ----- design/bole_ram.sv -----
// ----------------------------------------------------------------------------
// bole_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bole_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/bole_dp.sv -----
// ----------------------------------------------------------------------------
// bole_dp
// Datapath: operand registers, entry count, walk index, capacity limit,
// entry RAM and the result register.
// ----------------------------------------------------------------------------
module bole_dp import bole_pkg::*; #(
  parameter int unsigned CAPACITY = DEF_CAPACITY
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  dp_cmd_t                     cmd_i,
  output dp_stat_t                    stat_o,
  input  logic        [ACT_W-1:0]     action_i,
  input  logic signed [VAL_W-1:0]     value_i,
  input  logic        [POS_W-1:0]     position_i,
  input  logic                        cfg_we_i,
  input  logic        [LIM_W-1:0]     cfg_wdata_i,
  output logic        [STAT_W-1:0]    status_o,
  output logic signed [VAL_W-1:0]     removed_value_o,
  output logic        [FND_W-1:0]     found_position_o,
  output logic        [CNT_OUT_W-1:0] entry_count_o,
  output logic                        is_empty_flag_o,
  output logic                        is_full_flag_o
);

  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  logic        [ACT_W-1:0]  act_q;
  logic signed [VAL_W-1:0]  val_q;
  logic        [POS_W-1:0]  pos_q;
  logic        [CNT_W-1:0]  cnt_q, cnt_d;
  logic        [IDX_W-1:0]  idx_q, idx_d;
  logic        [LIM_W-1:0]  lim_q;
  logic        [STAT_W-1:0] status_q;
  logic signed [VAL_W-1:0]  taken_q;
  logic        [FND_W-1:0]  found_q;

  logic        [STAT_W-1:0]    out_status_q;
  logic signed [VAL_W-1:0]     out_removed_q;
  logic        [FND_W-1:0]     out_found_q;
  logic        [CNT_OUT_W-1:0] out_count_q;
  logic                        out_empty_q;
  logic                        out_full_q;

  logic [CMP_W-1:0] cnt_ext, pos_ext, idx_ext, lim_ext, cap_c, eff_lim, at_w;
  logic [IDX_W-1:0] at;
  logic [IDX_W-1:0] raddr;
  logic [VAL_W-1:0] rdata;
  logic [VAL_W-1:0] wdata;
  logic             full;

  assign cnt_ext = CMP_W'(cnt_q);
  assign pos_ext = CMP_W'(pos_q);
  assign idx_ext = CMP_W'(idx_q);
  assign lim_ext = CMP_W'(lim_q);
  assign cap_c   = CMP_W'(CAPACITY);

  // clamp the programmed limit into 1..CAPACITY
  always_comb begin
    if (lim_ext == '0) begin
      eff_lim = CMP_W'(1);
    end else if (lim_ext > cap_c) begin
      eff_lim = cap_c;
    end else begin
      eff_lim = lim_ext;
    end
  end

  assign full = (cnt_ext >= eff_lim);

  // target position of the current action
  always_comb begin
    unique case (act_q)
      ACT_INS_BACK: at_w = cnt_ext;
      ACT_INS_AT:   at_w = (pos_ext >= cnt_ext) ? cnt_ext : pos_ext;
      ACT_REM_BACK: at_w = cnt_ext - CMP_W'(1);
      ACT_REM_AT:   at_w = pos_ext;
      default:      at_w = '0;
    endcase
  end

  assign at = at_w[IDX_W-1:0];

  assign stat_o.act     = act_q;
  assign stat_o.full    = full;
  assign stat_o.empty   = (cnt_q == '0);
  assign stat_o.rem_bad = (act_q == ACT_REM_AT) && (pos_ext >= cnt_ext);
  assign stat_o.at_idx  = (idx_q == at);
  assign stat_o.last    = ((idx_ext + CMP_W'(1)) >= cnt_ext);
  assign stat_o.match   = (rdata == val_q);

  always_comb begin
    unique case (cmd_i.rd_sel)
      RD_AT:   raddr = at;
      RD_IDX:  raddr = idx_q;
      RD_PREV: raddr = idx_q - IDX_W'(1);
      RD_NEXT: raddr = idx_q + IDX_W'(1);
      default: raddr = idx_q;
    endcase
  end

  assign wdata = cmd_i.wr_from_ram ? rdata : val_q;

  bole_ram #(
    .WIDTH (VAL_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_en),
    .waddr_i (idx_q),
    .wdata_i (wdata),
    .re_i    (cmd_i.rd_en),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.cnt_inc) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (cmd_i.cnt_dec) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_comb begin
    idx_d = idx_q;
    priority if (cmd_i.idx_cnt) begin
      idx_d = cnt_ext[IDX_W-1:0];
    end else if (cmd_i.idx_at) begin
      idx_d = at;
    end else if (cmd_i.idx_zero) begin
      idx_d = '0;
    end else if (cmd_i.idx_inc) begin
      idx_d = idx_q + IDX_W'(1);
    end else if (cmd_i.idx_dec) begin
      idx_d = idx_q - IDX_W'(1);
    end else begin
      idx_d = idx_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      idx_q <= '0;
      lim_q <= LIM_RESET;
    end else begin
      cnt_q <= cnt_d;
      idx_q <= idx_d;
      if (cfg_we_i) begin
        lim_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      act_q    <= action_i;
      val_q    <= value_i;
      pos_q    <= position_i;
      status_q <= ST_OK;
      taken_q  <= '0;
      found_q  <= '0;
    end else begin
      if (cmd_i.status_load) begin
        status_q <= cmd_i.status_code;
      end
      if (cmd_i.take) begin
        taken_q <= rdata;
      end
      if (cmd_i.found) begin
        found_q <= idx_ext[FND_W-1:0];
      end
    end
    if (cmd_i.out_load) begin
      out_status_q  <= status_q;
      out_removed_q <= taken_q;
      out_found_q   <= found_q;
      out_count_q   <= cnt_ext[CNT_OUT_W-1:0];
      out_empty_q   <= (cnt_q == '0);
      out_full_q    <= full;
    end
  end

  assign status_o         = out_status_q;
  assign removed_value_o  = out_removed_q;
  assign found_position_o = out_found_q;
  assign entry_count_o    = out_count_q;
  assign is_empty_flag_o  = out_empty_q;
  assign is_full_flag_o   = out_full_q;

`ifndef SYNTH
  a_cnt_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cnt_inc |-> (cnt_ext < cap_c))
    else $error("entry count grows past capacity");

  a_cnt_one_way : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.cnt_inc && cmd_i.cnt_dec))
    else $error("entry count told to grow and shrink at once");

  a_write_in_list : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wr_en |-> (idx_ext <= cnt_ext))
    else $error("entry write beyond the list tail");
`endif

endmodule

// ----- design/bole_ctrl.sv -----
// ----------------------------------------------------------------------------
// bole_ctrl
// Controller: sequences each action through the entry RAM one entry at a
// time and owns the input and output handshakes.
// ----------------------------------------------------------------------------
module bole_ctrl import bole_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DISP     = 4'd1;
  localparam logic [3:0] S_INS_CHK  = 4'd2;
  localparam logic [3:0] S_INS_MOV  = 4'd3;
  localparam logic [3:0] S_REM_TAKE = 4'd4;
  localparam logic [3:0] S_REM_CHK  = 4'd5;
  localparam logic [3:0] S_REM_MOV  = 4'd6;
  localparam logic [3:0] S_SRC_RD   = 4'd7;
  localparam logic [3:0] S_SRC_CMP  = 4'd8;
  localparam logic [3:0] S_FINISH   = 4'd9;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  dp_cmd_t    cmd;

  always_comb begin
    cmd     = '0;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd.load_in = 1'b1;
          state_d     = S_DISP;
        end
      end
      S_DISP: begin
        unique case (stat_i.act)
          ACT_INS_FRONT, ACT_INS_BACK, ACT_INS_AT: begin
            if (stat_i.full) begin
              cmd.status_load = 1'b1;
              cmd.status_code = ST_FULL;
              state_d         = S_FINISH;
            end else begin
              cmd.idx_cnt = 1'b1;
              state_d     = S_INS_CHK;
            end
          end
          ACT_REM_FRONT, ACT_REM_BACK, ACT_REM_AT: begin
            priority if (stat_i.empty) begin
              cmd.status_load = 1'b1;
              cmd.status_code = ST_EMPTY;
              state_d         = S_FINISH;
            end else if (stat_i.rem_bad) begin
              cmd.status_load = 1'b1;
              cmd.status_code = ST_RANGE;
              state_d         = S_FINISH;
            end else begin
              cmd.idx_at = 1'b1;
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = RD_AT;
              state_d    = S_REM_TAKE;
            end
          end
          ACT_SEARCH: begin
            cmd.status_load = 1'b1;
            if (stat_i.empty) begin
              cmd.status_code = ST_EMPTY;
              state_d         = S_FINISH;
            end else begin
              cmd.status_code = ST_RANGE;
              cmd.idx_zero    = 1'b1;
              state_d         = S_SRC_RD;
            end
          end
          default: state_d = S_FINISH;
        endcase
      end
      S_INS_CHK: begin
        if (stat_i.at_idx) begin
          // drop the new word into the gap
          cmd.wr_en   = 1'b1;
          cmd.cnt_inc = 1'b1;
          state_d     = S_FINISH;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_PREV;
          state_d    = S_INS_MOV;
        end
      end
      S_INS_MOV: begin
        cmd.wr_en       = 1'b1;
        cmd.wr_from_ram = 1'b1;
        cmd.idx_dec     = 1'b1;
        state_d         = S_INS_CHK;
      end
      S_REM_TAKE: begin
        cmd.take = 1'b1;
        state_d  = S_REM_CHK;
      end
      S_REM_CHK: begin
        if (stat_i.last) begin
          cmd.cnt_dec = 1'b1;
          state_d     = S_FINISH;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_NEXT;
          state_d    = S_REM_MOV;
        end
      end
      S_REM_MOV: begin
        cmd.wr_en       = 1'b1;
        cmd.wr_from_ram = 1'b1;
        cmd.idx_inc     = 1'b1;
        state_d         = S_REM_CHK;
      end
      S_SRC_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_IDX;
        state_d    = S_SRC_CMP;
      end
      S_SRC_CMP: begin
        priority if (stat_i.match) begin
          cmd.found       = 1'b1;
          cmd.status_load = 1'b1;
          cmd.status_code = ST_OK;
          state_d         = S_FINISH;
        end else if (stat_i.last) begin
          state_d = S_FINISH;
        end else begin
          cmd.idx_inc = 1'b1;
          state_d     = S_SRC_RD;
        end
      end
      S_FINISH: begin
        // hold until the result register is free
        if (!out_valid_q || !out_stall_i) begin
          cmd.out_load = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd.out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

`ifndef SYNTH
  a_result_from_finish : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_FINISH))
    else $error("result word raised outside the finish step");
`endif

endmodule

// ----- design/bounded_ordered_list_engine.sv -----
// ----------------------------------------------------------------------------
// bounded_ordered_list_engine
// Bounded ordered list of signed 32-bit words with a programmable limit.
// Each input word carries one action (insert front/back/at, remove
// front/back/at, search) and yields exactly one result word with status,
// removed value, found position, entry count and empty/full flags. The
// entries live in a single-port-write RAM, and every move of an entry costs
// one RAM read and one RAM write. A new word is taken once the previous one
// has reached the result register; the result register holds its word
// while the output is stalled. The user must write the limit register
// with cfg_we_i only while no word is in flight; the block does not
// enforce this. A value of 0 acts as 1 and values above CAPACITY act as
// CAPACITY.
// ----------------------------------------------------------------------------
module bounded_ordered_list_engine import bole_pkg::*; #(
  parameter int unsigned CAPACITY = DEF_CAPACITY
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic        [ACT_W-1:0]     action_i,
  input  logic signed [VAL_W-1:0]     value_i,
  input  logic        [POS_W-1:0]     position_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic        [STAT_W-1:0]    status_o,
  output logic signed [VAL_W-1:0]     removed_value_o,
  output logic        [FND_W-1:0]     found_position_o,
  output logic        [CNT_OUT_W-1:0] entry_count_o,
  output logic                        is_empty_flag_o,
  output logic                        is_full_flag_o,
  input  logic                        cfg_we_i,
  input  logic        [LIM_W-1:0]     cfg_wdata_i
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  bole_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  bole_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .action_i         (action_i),
    .value_i          (value_i),
    .position_i       (position_i),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .status_o         (status_o),
    .removed_value_o  (removed_value_o),
    .found_position_o (found_position_o),
    .entry_count_o    (entry_count_o),
    .is_empty_flag_o  (is_empty_flag_o),
    .is_full_flag_o   (is_full_flag_o)
  );

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: bounded_ordered_list_engine testbench
// Drives list operations through the valid/stall input channel and predicts
// every result word with a behavioral copy of the list and its limit.
// Received words are compared field by field in order. The run covers a short
// directed sequence, then random phases with different limits and idle
// patterns.
// ----------------------------------------------------------------------------
module tb;
  import bole_pkg::*;

  localparam logic [ACT_W-1:0] ACT_NOP = 3'd7;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

  typedef struct {
    logic [STAT_W-1:0]       status;
    logic signed [VAL_W-1:0] removed_value;
    logic [FND_W-1:0]        found_position;
    logic [CNT_OUT_W-1:0]    entry_count;
    logic                    no_entries;
    logic                    is_full;
  } list_result_t;

  class list_scoreboard;
    logic signed [VAL_W-1:0] entries [DEF_CAPACITY];
    int unsigned             held;
    logic [LIM_W-1:0]        limit;
    list_result_t            expected_results [$];
    int                      errors;

    function new();
      held   = 0;
      limit  = LIM_RESET;
      errors = 0;
    endfunction

    function int unsigned eff_limit();
      if (limit == 0) return 1;
      if (limit > DEF_CAPACITY) return DEF_CAPACITY;
      return limit;
    endfunction

    function logic [STAT_W-1:0] insert_entry(int unsigned at, logic signed [VAL_W-1:0] val);
      if (held >= eff_limit()) return ST_FULL;
      // positions past the tail append
      if (at > held) at = held;
      for (int unsigned i = held; i > at; i--) entries[i] = entries[i-1];
      entries[at] = val;
      held++;
      return ST_OK;
    endfunction

    function logic [STAT_W-1:0] remove_entry(int unsigned at,
                                             output logic signed [VAL_W-1:0] taken);
      taken = '0;
      if (held == 0) return ST_EMPTY;
      if (at >= held) return ST_RANGE;
      taken = entries[at];
      for (int unsigned i = at; i + 1 < held; i++) entries[i] = entries[i+1];
      held--;
      return ST_OK;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function void note_word(logic [ACT_W-1:0] act, logic signed [VAL_W-1:0] val,
                            logic [POS_W-1:0] pos);
      list_result_t r;
      r.status         = ST_OK;
      r.removed_value  = '0;
      r.found_position = '0;
      case (act)
        ACT_INS_FRONT: r.status = insert_entry(0, val);
        ACT_INS_BACK:  r.status = insert_entry(held, val);
        ACT_INS_AT:    r.status = insert_entry(pos, val);
        ACT_REM_FRONT: r.status = remove_entry(0, r.removed_value);
        // empty list is caught before the wrapped index is used
        ACT_REM_BACK:  r.status = remove_entry(held - 1, r.removed_value);
        ACT_REM_AT:    r.status = remove_entry(pos, r.removed_value);
        ACT_SEARCH: begin
          if (held == 0) begin
            r.status = ST_EMPTY;
          end else begin
            r.status = ST_RANGE;
            for (int i = 0; i < held; i++) begin
              if (entries[i] == val) begin
                r.status         = ST_OK;
                r.found_position = FND_W'(i);
                break;
              end
            end
          end
        end
        default: ;
      endcase
      r.entry_count = CNT_OUT_W'(held);
      r.no_entries  = (held == 0);
      r.is_full     = (held >= eff_limit());
      expected_results.push_back(r);
    endfunction

    function void check_word(list_result_t got);
      list_result_t want;
      if (expected_results.size() == 0) begin
        $error("result word with no operation pending");
        errors++;
        return;
      end
      want = expected_results.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      if (got.removed_value !== want.removed_value) begin
        $error("removed_value: expected %0d, got %0d", want.removed_value, got.removed_value);
        errors++;
      end
      if (got.found_position !== want.found_position) begin
        $error("found_position: expected %0d, got %0d", want.found_position,
               got.found_position);
        errors++;
      end
      if (got.entry_count !== want.entry_count) begin
        $error("entry_count: expected %0d, got %0d", want.entry_count, got.entry_count);
        errors++;
      end
      if (got.no_entries !== want.no_entries) begin
        $error("is_empty_flag: expected %0d, got %0d", want.no_entries, got.no_entries);
        errors++;
      end
      if (got.is_full !== want.is_full) begin
        $error("is_full_flag: expected %0d, got %0d", want.is_full, got.is_full);
        errors++;
      end
    endfunction
  endclass

  logic                        clk_i;
  logic                        rst_ni       = 1'b0;
  logic                        in_valid_i   = 1'b0;
  logic                        in_stall_o;
  logic        [ACT_W-1:0]     action_i     = '0;
  logic signed [VAL_W-1:0]     value_i      = '0;
  logic        [POS_W-1:0]     position_i   = '0;
  logic                        out_valid_o;
  logic                        out_stall_i  = 1'b0;
  logic        [STAT_W-1:0]    status_o;
  logic signed [VAL_W-1:0]     removed_value_o;
  logic        [FND_W-1:0]     found_position_o;
  logic        [CNT_OUT_W-1:0] entry_count_o;
  logic                        is_empty_flag_o;
  logic                        is_full_flag_o;
  logic                        cfg_we_i     = 1'b0;
  logic        [LIM_W-1:0]     cfg_wdata_i  = '0;

  list_scoreboard sb;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  logic signed [VAL_W-1:0] value_pool [8] = '{
    32'sd0, -32'sd1, 32'sd1, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd42, -32'sd42,
    32'sh5A5A_5A5A
  };

  bounded_ordered_list_engine u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .action_i         (action_i),
    .value_i          (value_i),
    .position_i       (position_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .removed_value_o  (removed_value_o),
    .found_position_o (found_position_o),
    .entry_count_o    (entry_count_o),
    .is_empty_flag_o  (is_empty_flag_o),
    .is_full_flag_o   (is_full_flag_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i)
  );

  always begin
    clk_i = 1'b0;
    #5ns;
    clk_i = 1'b1;
    #5ns;
  end

  // result side: check accepted words, then pick the next stall
  always @(posedge clk_i) begin
    list_result_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.status         = status_o;
      got.removed_value  = removed_value_o;
      got.found_position = found_position_o;
      got.entry_count    = entry_count_o;
      got.no_entries     = is_empty_flag_o;
      got.is_full        = is_full_flag_o;
      sb.check_word(got);
    end
    out_stall_i <= rst_ni && ($urandom_range(99) < recv_idle_pct);
  end

  task automatic send_word(logic [ACT_W-1:0] act, logic signed [VAL_W-1:0] val,
                           logic [POS_W-1:0] pos);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i   <= act;
    value_i    <= val;
    position_i <= pos;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_word(act, val, pos);
  endtask

  // hold the input side until every pending word has come back
  task automatic drain_list();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic run_phase(logic [LIM_W-1:0] lim, idle_mode_e mode, int count, int ins_bias);
    logic [ACT_W-1:0]        act;
    logic signed [VAL_W-1:0] val;
    logic [POS_W-1:0]        pos;
    int unsigned             pick;
    drain_list();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= lim;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.limit = lim;
    case (mode)
      IDLE_NONE: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      IDLE_SEND: begin send_idle_pct = 62; recv_idle_pct = 0;  end
      IDLE_RECV: begin send_idle_pct = 0;  recv_idle_pct = 62; end
      default:   begin send_idle_pct = 22; recv_idle_pct = 22; end
    endcase
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < ins_bias) act = ACT_W'(ACT_INS_FRONT + $urandom_range(2));
      else if (pick < 96) act = ACT_W'(ACT_REM_FRONT + $urandom_range(3));
      else act = ACT_NOP;
      // mostly positions near the list, sometimes anything the field holds
      if ($urandom_range(9) == 0) pos = POS_W'($urandom_range(31));
      else pos = POS_W'($urandom_range(sb.held + 1));
      if ($urandom_range(3) == 0) val = $urandom;
      else val = value_pool[$urandom_range(7)];
      send_word(act, val, pos);
    end
  endtask

  initial begin
    sb = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty list, no-op, then build and take apart a short list
    send_word(ACT_SEARCH,    32'sd0,           5'd0);
    send_word(ACT_REM_FRONT, 32'sd0,           5'd0);
    send_word(ACT_REM_BACK,  32'sd0,           5'd0);
    send_word(ACT_REM_AT,    32'sd0,           5'd0);
    send_word(ACT_NOP,       32'sd0,           5'd0);
    send_word(ACT_INS_FRONT, 32'sh7FFF_FFFF,   5'd0);
    send_word(ACT_INS_BACK,  32'sh8000_0000,   5'd0);
    send_word(ACT_INS_AT,    -32'sd1,          5'd1);
    send_word(ACT_INS_AT,    32'sd0,           5'd31);
    send_word(ACT_INS_FRONT, 32'sh5555_5555,   5'd0);
    send_word(ACT_INS_AT,    32'shAAAA_AAAA,   5'd0);
    send_word(ACT_SEARCH,    -32'sd1,          5'd0);
    send_word(ACT_SEARCH,    32'sd0,           5'd0);
    send_word(ACT_SEARCH,    32'sd12345,       5'd0);
    send_word(ACT_REM_AT,    32'sd0,           5'd31);
    send_word(ACT_REM_AT,    32'sd0,           5'd6);
    send_word(ACT_REM_AT,    32'sd0,           5'd2);
    send_word(ACT_REM_FRONT, 32'sd0,           5'd0);
    send_word(ACT_REM_BACK,  32'sd0,           5'd0);
    send_word(ACT_NOP,       32'sd0,           5'd0);

    // limit below the held count first, then the clamped extremes
    run_phase(5'd2,  IDLE_NONE, 20, 50);
    run_phase(5'd0,  IDLE_SEND, 20, 50);
    run_phase(5'd16, IDLE_RECV, 90, 70);
    run_phase(5'd31, IDLE_BOTH, 90, 40);
    run_phase(5'd1,  IDLE_NONE, 30, 50);
    run_phase(5'd8,  IDLE_SEND, 80, 60);
    run_phase(5'd16, IDLE_NONE, 80, 80);
    run_phase(LIM_W'($urandom_range(31)), IDLE_RECV, 90, 30);

    drain_list();
    repeat (40) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[bounded_ordered_list_engine] OK");
    end else begin
      $display("[bounded_ordered_list_engine] ERROR");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("[bounded_ordered_list_engine] ERROR");
    $finish;
  end

endmodule
